@@ rtl/stk_calc_pkg.sv @@
// Shared types, codes and the control store for the stack calculator.
// Used by stk_calc_div and stack_calculator_unit; depends on nothing.

package stk_calc_pkg;

   localparam int DATA_W      = 32;
   localparam int MODE_W      = 3;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 7;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POP  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ADD  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SUB  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MUL  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DIV  = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ONE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      logic [STATUS_W-1:0]      status;
      logic                     stack_empty;
      logic [COUNT_OUT_W-1:0]   entry_count;
   } rsp_type;

   // microprogram step addresses
   typedef logic [2:0] step_type;
   localparam step_type STEP_IDLE = 3'd0;
   localparam step_type STEP_PUSH = 3'd1;
   localparam step_type STEP_POP  = 3'd2;
   localparam step_type STEP_ARB  = 3'd3;
   localparam step_type STEP_ARX  = 3'd4;
   localparam step_type STEP_DIVW = 3'd5;
   localparam step_type STEP_WB   = 3'd6;
   localparam step_type STEP_FIN  = 3'd7;

   // sequencing: plain jump, dispatch on request, arithmetic branch, wait on divider
   typedef enum logic [1:0] {
      SEQ_GOTO  = 2'd0,
      SEQ_MAP   = 2'd1,
      SEQ_ARITH = 2'd2,
      SEQ_WAIT  = 2'd3
   } seq_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2
   } cnt_op_type;

   localparam logic RD_TOP    = 1'b0;
   localparam logic RD_NEXT   = 1'b1;
   localparam logic WSRC_PUSH = 1'b0;
   localparam logic WSRC_RES  = 1'b1;

   typedef struct packed {
      logic       rd_en;
      logic       rd_sel;
      logic       cap_a;
      logic       ld_res;
      logic       we;
      logic       wsrc;
      cnt_op_type cnt_op;
      logic       pop_out;
      logic       fin;
      seq_type    seq;
      step_type   target;
   } ctrl_type;

   // control store: one word per step
   function automatic ctrl_type ucode(step_type s);
      ctrl_type w;
      w = '0;
      w.cnt_op = CNT_HOLD;
      w.seq    = SEQ_GOTO;
      w.target = STEP_IDLE;
      case (s)
         STEP_IDLE: begin
            w.rd_en  = 1'b1;
            w.rd_sel = RD_TOP;
            w.seq    = SEQ_MAP;
         end
         STEP_PUSH: begin
            w.we     = 1'b1;
            w.wsrc   = WSRC_PUSH;
            w.cnt_op = CNT_INC;
            w.fin    = 1'b1;
         end
         STEP_POP: begin
            w.pop_out = 1'b1;
            w.cnt_op  = CNT_DEC;
            w.fin     = 1'b1;
         end
         STEP_ARB: begin
            w.cap_a  = 1'b1;
            w.rd_en  = 1'b1;
            w.rd_sel = RD_NEXT;
            w.target = STEP_ARX;
         end
         STEP_ARX: begin
            w.ld_res = 1'b1;
            w.seq    = SEQ_ARITH;
            w.target = STEP_WB;
         end
         STEP_DIVW: begin
            w.seq    = SEQ_WAIT;
            w.target = STEP_WB;
         end
         STEP_WB: begin
            w.we     = 1'b1;
            w.wsrc   = WSRC_RES;
            w.cnt_op = CNT_DEC;
            w.fin    = 1'b1;
         end
         STEP_FIN: begin
            w.fin = 1'b1;
         end
         default: begin
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

@@ rtl/stk_calc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module stk_calc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port, hold when not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/stk_calc_div.sv @@
// Iterative signed divider, truncating toward zero, one quotient bit a cycle.
// Depends on stk_calc_pkg for the data width.

module stk_calc_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [stk_calc_pkg::DATA_W-1:0]  dividend,
   input  logic [stk_calc_pkg::DATA_W-1:0]  divisor,
   output logic                             busy,
   output logic [stk_calc_pkg::DATA_W-1:0]  quotient
);

   localparam int DW = stk_calc_pkg::DATA_W;
   localparam int SW = $clog2(DW);

   logic          busy_ff;
   logic [SW-1:0] step_ff;
   logic          neg_ff;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dvs_ff;
   logic [DW-1:0] shifted;

   // one restoring step; remainder stays below the divisor magnitude
   always_comb begin
      shifted = {rem_ff[DW-2:0], quo_ff[DW-1]};
      if (shifted >= dvs_ff) begin
         rem_in = shifted - dvs_ff;
         quo_in = {quo_ff[DW-2:0], 1'b1};
      end else begin
         rem_in = shifted;
         quo_in = {quo_ff[DW-2:0], 1'b0};
      end
   end

   // control: run DW steps after start
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + SW'(1);
         if (step_ff == SW'(DW - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // datapath: load magnitudes, then shift and subtract
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[DW-1] ^ divisor[DW-1];
         quo_ff <= dividend[DW-1] ? (DW'(0) - dividend) : dividend;
         dvs_ff <= divisor[DW-1] ? (DW'(0) - divisor) : divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? (DW'(0) - quo_ff) : quo_ff;

endmodule

@@ rtl/stack_calculator_unit.sv @@
// Top level of the RPN stack calculator: microcoded sequencer, stack RAM, ALU.
// Depends on stk_calc_pkg, stk_calc_ram and stk_calc_div.
//
//   port group   | dir | handshake            | beat
//   req_*        | in  | req_valid/req_ready  | stk_calc_pkg::req_type (mode, push_value)
//   rsp_*        | out | rsp_valid/rsp_ready  | stk_calc_pkg::rsp_type (popped, status, count)
//
// Push, pop and operations refused at dispatch go straight to a finishing step; add,
// subtract, multiply and a divide refused for a zero operand pass the two reads of the
// single stack RAM read port first. Divide also waits on the one-bit-per-cycle divider.
// Reset clears the entry count and the sequencer; the stack RAM is not cleared.
// A new beat is taken while the previous result waits; a step that finishes holds
// until the result register is free.

module stack_calculator_unit #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  stk_calc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output stk_calc_pkg::rsp_type rsp_data
);

   localparam int DW     = stk_calc_pkg::DATA_W;
   localparam int CW     = $clog2(STACK_DEPTH + 1);
   localparam int AW     = $clog2(STACK_DEPTH);
   localparam int OUT_CW = stk_calc_pkg::COUNT_OUT_W;

   stk_calc_pkg::ctrl_type                    ctrl;
   stk_calc_pkg::step_type                    upc_ff, upc_in;
   logic [CW-1:0]                             count_ff, count_in;
   logic [stk_calc_pkg::MODE_W-1:0]           mode_ff;
   logic [DW-1:0]                             value_ff;
   logic [stk_calc_pkg::STATUS_W-1:0]         status_ff, status_in;
   logic [DW-1:0]                             a_ff;
   logic [DW-1:0]                             res_ff, res_in;
   logic                                      rsp_valid_ff, rsp_valid_in;
   stk_calc_pkg::rsp_type                     rsp_ff, rsp_in;

   logic                                      accept;
   logic                                      adv;
   logic                                      div_go;
   logic                                      div_busy;
   logic [DW-1:0]                             div_quo;
   logic                                      ram_we, ram_re;
   logic [AW-1:0]                             ram_waddr, ram_raddr;
   logic [DW-1:0]                             ram_wdata, ram_rdata;
   stk_calc_pkg::step_type                    map_step;
   logic [stk_calc_pkg::STATUS_W-1:0]         map_status;

   assign ctrl      = stk_calc_pkg::ucode(upc_ff);
   assign req_ready = (upc_ff == stk_calc_pkg::STEP_IDLE);
   assign accept    = req_valid && req_ready;
   // a finishing step advances only when the result register can take the beat
   assign adv       = !ctrl.fin || !rsp_valid_ff || rsp_ready;

   // dispatch: pick the entry step and any refusal from the request and count
   always_comb begin
      map_status = stk_calc_pkg::ST_OK;
      map_step   = stk_calc_pkg::STEP_FIN;
      case (req_data.mode)
         stk_calc_pkg::MODE_PUSH: begin
            if (count_ff == CW'(STACK_DEPTH)) begin
               map_status = stk_calc_pkg::ST_FULL;
            end else begin
               map_step = stk_calc_pkg::STEP_PUSH;
            end
         end
         stk_calc_pkg::MODE_POP: begin
            if (count_ff == '0) begin
               map_status = stk_calc_pkg::ST_EMPTY;
            end else begin
               map_step = stk_calc_pkg::STEP_POP;
            end
         end
         stk_calc_pkg::MODE_ADD, stk_calc_pkg::MODE_SUB,
         stk_calc_pkg::MODE_MUL, stk_calc_pkg::MODE_DIV: begin
            if (count_ff == '0) begin
               map_status = stk_calc_pkg::ST_EMPTY;
            end else if (count_ff == CW'(1)) begin
               map_status = stk_calc_pkg::ST_ONE;
            end else begin
               map_step = stk_calc_pkg::STEP_ARB;
            end
         end
         default: begin
            map_status = stk_calc_pkg::ST_OK;
         end
      endcase
   end

   // sequencer: next step, status and divider start
   always_comb begin
      upc_in    = upc_ff;
      status_in = status_ff;
      div_go    = 1'b0;
      case (ctrl.seq)
         stk_calc_pkg::SEQ_MAP: begin
            if (accept) begin
               upc_in    = map_step;
               status_in = map_status;
            end
         end
         stk_calc_pkg::SEQ_ARITH: begin
            if (mode_ff == stk_calc_pkg::MODE_DIV) begin
               if (a_ff == '0 || ram_rdata == '0) begin
                  status_in = stk_calc_pkg::ST_DIVZERO;
                  upc_in    = stk_calc_pkg::STEP_FIN;
               end else begin
                  div_go = 1'b1;
                  upc_in = stk_calc_pkg::STEP_DIVW;
               end
            end else begin
               upc_in = ctrl.target;
            end
         end
         stk_calc_pkg::SEQ_WAIT: begin
            if (!div_busy) begin
               upc_in = ctrl.target;
            end
         end
         stk_calc_pkg::SEQ_GOTO: begin
            if (adv) begin
               upc_in = ctrl.target;
            end
         end
         default: begin
            upc_in = stk_calc_pkg::STEP_IDLE;
         end
      endcase
   end

   // entry count update
   always_comb begin
      count_in = count_ff;
      if (adv) begin
         case (ctrl.cnt_op)
            stk_calc_pkg::CNT_INC:  count_in = count_ff + CW'(1);
            stk_calc_pkg::CNT_DEC:  count_in = count_ff - CW'(1);
            default:                count_in = count_ff;
         endcase
      end
   end

   // ALU: a is the top entry (a_ff), b arrives from the RAM read
   always_comb begin
      case (mode_ff)
         stk_calc_pkg::MODE_ADD: res_in = a_ff + ram_rdata;
         stk_calc_pkg::MODE_SUB: res_in = a_ff - ram_rdata;
         stk_calc_pkg::MODE_MUL: res_in = a_ff * ram_rdata;
         default:                res_in = '0;
      endcase
   end

   // stack RAM addressing
   assign ram_re    = ctrl.rd_en;
   assign ram_raddr = (ctrl.rd_sel == stk_calc_pkg::RD_NEXT) ? AW'(count_ff - CW'(2))
                                                             : AW'(count_ff - CW'(1));
   assign ram_we    = ctrl.we && adv;
   assign ram_waddr = (ctrl.wsrc == stk_calc_pkg::WSRC_PUSH) ? AW'(count_ff)
                                                             : AW'(count_ff - CW'(2));
   always_comb begin
      if (ctrl.wsrc == stk_calc_pkg::WSRC_PUSH) begin
         ram_wdata = value_ff;
      end else if (mode_ff == stk_calc_pkg::MODE_DIV) begin
         ram_wdata = div_quo;
      end else begin
         ram_wdata = res_ff;
      end
   end

   // result beat and its valid
   always_comb begin
      rsp_in.popped_value = ctrl.pop_out ? ram_rdata : '0;
      rsp_in.status       = status_ff;
      rsp_in.stack_empty  = (count_in == '0);
      rsp_in.entry_count  = OUT_CW'(count_in);
      if (ctrl.fin && adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= stk_calc_pkg::STEP_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (accept) begin
         mode_ff  <= req_data.mode;
         value_ff <= req_data.push_value;
      end
      if (ctrl.cap_a) begin
         a_ff <= ram_rdata;
      end
      if (ctrl.ld_res) begin
         res_ff <= res_in;
      end
      if (ctrl.fin && adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   stk_calc_ram #(
      .WIDTH (DW),
      .DEPTH (STACK_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   stk_calc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (a_ff),
      .divisor  (ram_rdata),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // count never passes the stack depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("entry count above stack depth");

   // no new beat is taken while a divide is running
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_busy)
      else $error("request taken during divide");

   // count moves only from a push, pop or write-back step
   a_count_src: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(upc_ff) == stk_calc_pkg::STEP_PUSH ||
          $past(upc_ff) == stk_calc_pkg::STEP_POP ||
          $past(upc_ff) == stk_calc_pkg::STEP_WB))
      else $error("entry count changed outside a stack step");

   // a refused divide never starts the divider
   a_div_refused: assert property (@(posedge clock) disable iff (reset)
      div_go |-> (a_ff != '0 && ram_rdata != '0))
      else $error("divider started with a zero operand");

endmodule
